### rtl/bdeq_pkg.sv
// Shared types and constants for the bounded double-ended queue.
`default_nettype none

package bdeq_pkg;

   // Field widths
   localparam int VALUE_W = 32;
   localparam int FUNC_W  = 3;
   localparam int CAP_W   = 5;

   // Capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Front and rear value reported when the queue holds nothing
   localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

   // Operation codes; codes above STATUS also act as status only
   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_STATUS     = 3'd4
   } func_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } state_type;

endpackage

`default_nettype wire

### rtl/bdeq_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module bdeq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr_a,
   input  wire logic [AW-1:0]    rd_addr_b,
   output logic      [WIDTH-1:0] rd_data_a,
   output logic      [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read ports; data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

### rtl/bounded_double_ended_queue.sv
// Top level of the bounded double-ended queue.
`default_nettype none

// A deque of signed 32-bit values kept in a ring buffer RAM of DEPTH entries, with
// front and back pointers and an entry count in flip-flops. Each request transaction
// carries one operation (push front, push back, pop front, pop back, status; unused
// codes act as status) and yields exactly one response transaction with the success
// flag, the front and rear values after the operation (-1 when empty), and empty/full
// flags. A request passes through IDLE, READ and LOAD: IDLE updates the pointers and writes a
// pushed value, READ reads the front and rear entries from the RAM, LOAD takes the
// registered read data into the response register. A stalled response holds LOAD
// only while the previous response is still held. The capacity register (reset 16,
// saturated to DEPTH) is written through the csr channel, which is always ready; write
// it only while no request is in flight. The RAM needs no clearing after reset.
module bounded_double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic        [bdeq_pkg::FUNC_W-1:0]  req_func,
   input  wire logic signed [bdeq_pkg::VALUE_W-1:0] req_value,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_ok,
   output logic signed      [bdeq_pkg::VALUE_W-1:0] rsp_front_value,
   output logic signed      [bdeq_pkg::VALUE_W-1:0] rsp_rear_value,
   output logic                                     rsp_is_empty,
   output logic                                     rsp_is_full,
   // configuration channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic        [bdeq_pkg::CAP_W-1:0]   csr_capacity
);

   import bdeq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   state_type state_ff, state_in;

   logic [CAP_W-1:0] capacity_ff;
   logic [AW-1:0]    front_ff, front_in;
   logic [AW-1:0]    back_ff, back_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    cap_eff;
   logic             has_room;
   logic             req_accept;

   // Per-transaction status held until the response is loaded
   logic ok_ff, ok_in;
   logic empty_ff, empty_in;
   logic full_ff, full_in;

   // Response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_load;
   logic                      rsp_free;
   logic                      rsp_ok_ff;
   logic signed [VALUE_W-1:0] rsp_front_ff;
   logic signed [VALUE_W-1:0] rsp_rear_ff;
   logic                      rsp_empty_ff;
   logic                      rsp_full_ff;

   // RAM ports
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic               ram_rd_en;
   logic [VALUE_W-1:0] ram_rd_front;
   logic [VALUE_W-1:0] ram_rd_rear;

   function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] idx);
      return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] idx);
      return (idx == '0) ? AW'(DEPTH - 1) : idx - 1'b1;
   endfunction

   // Capacity saturates at the built depth
   assign cap_eff  = (32'(capacity_ff) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(capacity_ff);
   assign has_room = count_ff < cap_eff;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Next state, pointer update and RAM control
   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      back_in     = back_ff;
      count_in    = count_ff;
      ok_in       = ok_ff;
      empty_in    = empty_ff;
      full_in     = full_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = back_ff;
      ram_rd_en   = 1'b0;
      rsp_load    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ok_in = 1'b1;
               case (req_func)
                  FUNC_PUSH_FRONT: begin
                     if (has_room) begin
                        front_in    = ring_dec(front_ff);
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = ring_dec(front_ff);
                        count_in    = count_ff + 1'b1;
                     end else begin
                        ok_in = 1'b0;
                     end
                  end
                  FUNC_PUSH_BACK: begin
                     if (has_room) begin
                        back_in     = ring_inc(back_ff);
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = back_ff;
                        count_in    = count_ff + 1'b1;
                     end else begin
                        ok_in = 1'b0;
                     end
                  end
                  FUNC_POP_FRONT: begin
                     if (count_ff != '0) begin
                        front_in = ring_inc(front_ff);
                        count_in = count_ff - 1'b1;
                     end else begin
                        ok_in = 1'b0;
                     end
                  end
                  FUNC_POP_BACK: begin
                     if (count_ff != '0) begin
                        back_in  = ring_dec(back_ff);
                        count_in = count_ff - 1'b1;
                     end else begin
                        ok_in = 1'b0;
                     end
                  end
                  default: begin
                     // status only
                  end
               endcase
               empty_in = (count_in == '0);
               full_in  = (count_in >= cap_eff);
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // front and rear entries from the updated pointers
            ram_rd_en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid: set on load, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_capacity;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ok_ff    <= ok_in;
      empty_ff <= empty_in;
      full_ff  <= full_in;
      if (rsp_load) begin
         rsp_ok_ff    <= ok_ff;
         rsp_empty_ff <= empty_ff;
         rsp_full_ff  <= full_ff;
         rsp_front_ff <= empty_ff ? EMPTY_VALUE : signed'(ram_rd_front);
         rsp_rear_ff  <= empty_ff ? EMPTY_VALUE : signed'(ram_rd_rear);
      end
   end

   bdeq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ring (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (unsigned'(req_value)),
      .rd_en     (ram_rd_en),
      .rd_addr_a (front_ff),
      .rd_addr_b (ring_dec(back_ff)),
      .rd_data_a (ram_rd_front),
      .rd_data_b (ram_rd_rear)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_rear_value  = rsp_rear_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;

`ifndef ASSERT_OFF
   // Entry count never exceeds the built depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(DEPTH))
      else $error("entry count above depth");

   // An accepted request always moves on to the RAM read
   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_READ))
      else $error("accepted request did not start its read");

   // An empty response reports -1 at both ends
   a_empty_values: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |->
         (rsp_front_value == EMPTY_VALUE) && (rsp_rear_value == EMPTY_VALUE))
      else $error("empty response carries entry values");

   // A response is loaded only when the output register is free
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten while held");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_bounded_double_ended_queue.sv
// Self-checking testbench for the bounded double-ended queue: directed table plus random traffic.
`default_nettype none

module tb_bounded_double_ended_queue;
   timeunit 1ns;
   timeprecision 1ps;
   import bdeq_pkg::*;

   localparam int DEPTH          = 16;
   localparam int LIMIT_CYCLES   = 400000;
   localparam int DRAIN_PAD      = 8;
   localparam int RAND_PER_PHASE = 300;
   localparam int NUM_PHASES     = 6;
   localparam int NUM_DIR        = 29;

   // Codes past STATUS that the block treats as status only
   localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_C = 3'd7;

   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

   // One response transaction
   typedef struct packed {
      logic                      ok;
      logic signed [VALUE_W-1:0] front_value;
      logic signed [VALUE_W-1:0] rear_value;
      logic                      is_empty;
      logic                      is_full;
   } rsp_fields_type;

   localparam rsp_fields_type NO_FIX = '0;

   // Directed rows either issue an operation or rewrite the capacity
   typedef enum logic {
      ROW_OP,
      ROW_CAP
   } row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic        [FUNC_W-1:0]  func;
      logic signed [VALUE_W-1:0] value;
      logic                      fixed;
      rsp_fields_type            exp;
   } dir_row_type;

   // Capacity rows carry the new capacity in the value column
   dir_row_type dir_table [NUM_DIR] = '{
      '{ROW_OP,  FUNC_STATUS,     32'sd0,  1'b1, '{1'b1, EMPTY_VALUE, EMPTY_VALUE, 1'b1, 1'b0}},
      '{ROW_OP,  FUNC_POP_FRONT,  32'sd0,  1'b1, '{1'b0, EMPTY_VALUE, EMPTY_VALUE, 1'b1, 1'b0}},
      '{ROW_OP,  FUNC_POP_BACK,   32'sd0,  1'b1, '{1'b0, EMPTY_VALUE, EMPTY_VALUE, 1'b1, 1'b0}},
      '{ROW_OP,  FUNC_PUSH_BACK,  VAL_MAX, 1'b1, '{1'b1, VAL_MAX, VAL_MAX, 1'b0, 1'b0}},
      '{ROW_OP,  FUNC_PUSH_FRONT, VAL_MIN, 1'b1, '{1'b1, VAL_MIN, VAL_MAX, 1'b0, 1'b0}},
      '{ROW_OP,  FUNC_PUSH_BACK,  32'sd0,  1'b0, NO_FIX},
      '{ROW_OP,  FUNC_SPARE_A,    32'sd3,  1'b0, NO_FIX},
      '{ROW_OP,  FUNC_SPARE_C,    -32'sd1, 1'b0, NO_FIX},
      '{ROW_OP,  FUNC_POP_BACK,   32'sd0,  1'b0, NO_FIX},
      '{ROW_OP,  FUNC_POP_FRONT,  32'sd0,  1'b0, NO_FIX},
      '{ROW_OP,  FUNC_POP_BACK,   32'sd0,  1'b1, '{1'b1, EMPTY_VALUE, EMPTY_VALUE, 1'b1, 1'b0}},
      // capacity of one: a single entry fills the queue
      '{ROW_CAP, FUNC_STATUS,     32'sd1,  1'b0, NO_FIX},
      '{ROW_OP,  FUNC_PUSH_FRONT, 32'sd5,  1'b1, '{1'b1, 32'sd5, 32'sd5, 1'b0, 1'b1}},
      '{ROW_OP,  FUNC_PUSH_BACK,  32'sd6,  1'b1, '{1'b0, 32'sd5, 32'sd5, 1'b0, 1'b1}},
      '{ROW_OP,  FUNC_POP_BACK,   32'sd0,  1'b1, '{1'b1, EMPTY_VALUE, EMPTY_VALUE, 1'b1, 1'b0}},
      // capacity zero: empty and full at once, every push refused
      '{ROW_CAP, FUNC_STATUS,     32'sd0,  1'b0, NO_FIX},
      '{ROW_OP,  FUNC_PUSH_BACK,  32'sd7,  1'b1, '{1'b0, EMPTY_VALUE, EMPTY_VALUE, 1'b1, 1'b1}},
      '{ROW_OP,  FUNC_SPARE_B,    32'sd0,  1'b1, '{1'b1, EMPTY_VALUE, EMPTY_VALUE, 1'b1, 1'b1}},
      // capacity above depth saturates
      '{ROW_CAP, FUNC_STATUS,     32'sd31, 1'b0, NO_FIX},
      '{ROW_OP,  FUNC_PUSH_BACK,  32'sd1,  1'b0, NO_FIX},
      '{ROW_OP,  FUNC_PUSH_BACK,  32'sd2,  1'b0, NO_FIX},
      '{ROW_OP,  FUNC_PUSH_FRONT, 32'sd3,  1'b0, NO_FIX},
      // capacity lowered below the held count: entries stay, pops drain them
      '{ROW_CAP, FUNC_STATUS,     32'sd2,  1'b0, NO_FIX},
      '{ROW_OP,  FUNC_PUSH_FRONT, 32'sd9,  1'b0, NO_FIX},
      '{ROW_OP,  FUNC_STATUS,     32'sd0,  1'b0, NO_FIX},
      '{ROW_OP,  FUNC_POP_FRONT,  32'sd0,  1'b0, NO_FIX},
      '{ROW_OP,  FUNC_POP_FRONT,  32'sd0,  1'b0, NO_FIX},
      '{ROW_OP,  FUNC_POP_BACK,   32'sd0,  1'b0, NO_FIX},
      '{ROW_CAP, FUNC_STATUS,     32'sd16, 1'b0, NO_FIX}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid    = 1'b0;
   logic                      req_stall;
   logic        [FUNC_W-1:0]  req_func     = '0;
   logic signed [VALUE_W-1:0] req_value    = '0;
   logic                      rsp_valid;
   logic                      rsp_stall    = 1'b0;
   logic                      rsp_ok;
   logic signed [VALUE_W-1:0] rsp_front_value;
   logic signed [VALUE_W-1:0] rsp_rear_value;
   logic                      rsp_is_empty;
   logic                      rsp_is_full;
   logic                      csr_valid    = 1'b0;
   logic                      csr_ready;
   logic        [CAP_W-1:0]   csr_capacity = '0;

   // Typed expectation that travels with a directed request
   logic           req_fixed     = 1'b0;
   rsp_fields_type req_fixed_exp = '0;

   // Mirror of the deque contents
   logic signed [VALUE_W-1:0] slots [DEPTH];
   logic [3:0]                head_ptr  = '0;
   logic [3:0]                tail_ptr  = '0;
   logic [CAP_W-1:0]          held      = '0;
   logic [CAP_W-1:0]          cap_model = CAP_RESET;

   rsp_fields_type pending_results [$];
   int             fail_count  = 0;
   int             cycle_count = 0;
   int             burst_left  = 0;
   logic [9:0]     stall_tick  = '0;

   bounded_double_ended_queue #(
      .DEPTH(DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_front_value(rsp_front_value),
      .rsp_rear_value (rsp_rear_value),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_capacity   (csr_capacity)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one operation to the mirror and return the response it should produce
   function automatic rsp_fields_type apply_deque_op(logic [FUNC_W-1:0] f,
                                                     logic signed [VALUE_W-1:0] v);
      rsp_fields_type   r;
      logic [CAP_W-1:0] limit;
      limit = (cap_model > DEPTH) ? CAP_W'(DEPTH) : cap_model;
      r.ok  = 1'b1;
      case (f)
         FUNC_PUSH_FRONT: begin
            if (held < limit) begin
               head_ptr        = head_ptr - 1'b1;
               slots[head_ptr] = v;
               held            = held + 1'b1;
            end else begin
               r.ok = 1'b0;
            end
         end
         FUNC_PUSH_BACK: begin
            if (held < limit) begin
               slots[tail_ptr] = v;
               tail_ptr        = tail_ptr + 1'b1;
               held            = held + 1'b1;
            end else begin
               r.ok = 1'b0;
            end
         end
         FUNC_POP_FRONT: begin
            if (held != 0) begin
               head_ptr = head_ptr + 1'b1;
               held     = held - 1'b1;
            end else begin
               r.ok = 1'b0;
            end
         end
         FUNC_POP_BACK: begin
            if (held != 0) begin
               tail_ptr = tail_ptr - 1'b1;
               held     = held - 1'b1;
            end else begin
               r.ok = 1'b0;
            end
         end
         default: ;
      endcase
      r.front_value = (held != 0) ? slots[head_ptr] : EMPTY_VALUE;
      r.rear_value  = (held != 0) ? slots[tail_ptr - 1'b1] : EMPTY_VALUE;
      r.is_empty    = (held == 0);
      r.is_full     = (held >= limit);
      return r;
   endfunction

   task automatic check_field(string name, logic signed [VALUE_W-1:0] want,
                              logic signed [VALUE_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Send one request transaction; bursts of back-to-back requests with random gaps
   task automatic drive_op(logic [FUNC_W-1:0] f, logic signed [VALUE_W-1:0] v,
                           logic fixed, rsp_fields_type exp);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_valid     <= 1'b1;
      req_func      <= f;
      req_value     <= v;
      req_fixed     <= fixed;
      req_fixed_exp <= exp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   // Stop sending and let every outstanding response come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] c);
      csr_valid    <= 1'b1;
      csr_capacity <= c;
      do @(posedge clock); while (!csr_ready);
      cap_model = c;
      csr_valid <= 1'b0;
   endtask

   // Response stall: quiet, coin flip, fixed pattern and heavy stretches in turn
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1'b1;
      case (stall_tick[9:8])
         2'd0:    rsp_stall <= 1'b0;
         2'd1:    rsp_stall <= ($urandom_range(0, 1) == 1);
         2'd2:    rsp_stall <= (stall_tick[2:0] < 3'd3);
         default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
   end

   // Predict on each accepted request, compare on each accepted response
   always @(posedge clock) begin : monitor
      rsp_fields_type predicted;
      rsp_fields_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted = apply_deque_op(req_func, req_value);
            pending_results.push_back(req_fixed ? req_fixed_exp : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("response transaction with no request outstanding");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("ok", VALUE_W'(want.ok), VALUE_W'(rsp_ok));
               check_field("front_value", want.front_value, rsp_front_value);
               check_field("rear_value", want.rear_value, rsp_rear_value);
               check_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(rsp_is_empty));
               check_field("is_full", VALUE_W'(want.is_full), VALUE_W'(rsp_is_full));
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [CAP_W-1:0]          phase_caps [NUM_PHASES];
      logic [FUNC_W-1:0]         op;
      logic signed [VALUE_W-1:0] val;
      logic                      filling;
      int                        run_left;
      int                        roll;

      phase_caps = '{CAP_RESET, 5'd31, 5'd1, 5'd0, 5'd17, 5'd8};
      phase_caps[NUM_PHASES-1] = CAP_W'($urandom_range(2, 15));
      filling  = 1'b1;
      run_left = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (int i = 0; i < NUM_DIR; i++) begin
         if (dir_table[i].kind == ROW_CAP) begin
            wait_idle();
            write_capacity(dir_table[i].value[CAP_W-1:0]);
         end else begin
            drive_op(dir_table[i].func, dir_table[i].value, dir_table[i].fixed,
                     dir_table[i].exp);
         end
      end

      // Random phases, each under its own capacity; runs alternate filling and draining
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         write_capacity(phase_caps[p]);
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            if (run_left == 0) begin
               filling  = !filling;
               run_left = $urandom_range(4, 40);
            end
            run_left--;

            roll = $urandom_range(0, 99);
            if (roll < 6)
               op = FUNC_W'($urandom_range(FUNC_STATUS, FUNC_SPARE_C));
            else if (roll < (filling ? 80 : 26))
               op = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
            else
               op = $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;

            case ($urandom_range(0, 19))
               0:       val = VAL_MAX;
               1:       val = VAL_MIN;
               2:       val = '0;
               3:       val = EMPTY_VALUE;
               default: val = $urandom;
            endcase

            // occasionally hold off until the queue of responses is empty
            if ($urandom_range(0, 99) == 0)
               wait_idle();
            drive_op(op, val, 1'b0, NO_FIX);
         end
      end

      wait_idle();
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire
